// File: hw/rtl/lbpr_pkg.sv
// Package for the leaky bucket priority remarker.
// Holds the shared types, register indexes and constants; depends on nothing.
package lbpr_pkg;

    // Meter scaling: bucket units per byte are 8 bits times the tick rate.
    localparam int unsigned TICKS_PER_SECOND = 100;
    localparam logic [31:0] ADD_SCALE        = 32'(8 * TICKS_PER_SECOND);

    // Register reset values.
    localparam logic [3:0]  METER_ENABLE_RESET = 4'd0;
    localparam logic [23:0] QUEUE_MAP_RESET    = 24'd9024641;
    localparam logic [31:0] MIN_RATE_RESET     = 32'(15 * 1024);
    localparam logic [31:0] BUCKET_SIZE_RESET  = 32'(2000 * 8 * TICKS_PER_SECOND);

    // Codes.
    localparam logic [3:0] METER_ON       = 4'd1;
    localparam logic [2:0] METERED_QUEUE  = 3'd1;
    localparam logic [2:0] PROMOTED_QUEUE = 3'd4;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_METER_ENABLE = 2'd0,
        REG_QUEUE_MAP    = 2'd1,
        REG_MIN_RATE     = 2'd2,
        REG_BUCKET_SIZE  = 2'd3
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic [3:0]  meter_enable;
        logic [23:0] queue_map;
        logic [31:0] min_rate;
        logic [31:0] bucket_size;
    } t_cfg;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic        metered;   // metering on and mapped queue is the metered one
        logic [2:0]  queue;     // mapped queue
        logic [31:0] add_bits;  // length scaled to bucket units
        logic [31:0] now;       // tick of arrival
        logic [31:0] now_prod;  // now * min_rate, modulo 2^32
    } t_item;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

endpackage

// File: hw/rtl/lbpr_front.sv
// Front part of the remarker: maps the priority to a queue and precomputes
// the per-item products. Depends on lbpr_pkg.
module lbpr_front
    import lbpr_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [2:0]  i_priority_req,
    input  logic [15:0] i_length,
    input  logic [31:0] i_now,
    output t_item       o_item
);

    logic [2:0]  map_q;
    logic [31:0] now_prod;

    // Queue table lookup: entry i sits at bits 3i+2 to 3i.
    always_comb begin
        map_q = i_cfg.queue_map[i_priority_req*3 +: 3];
    end

    // Only the low 32 bits of the product are needed.
    assign now_prod = i_now * i_cfg.min_rate;

    // Classification and products that do not depend on the bucket state.
    always_comb begin
        o_item.metered  = (i_cfg.meter_enable == METER_ON) && (map_q == METERED_QUEUE);
        o_item.queue    = map_q;
        o_item.add_bits = 32'(i_length) * ADD_SCALE;
        o_item.now      = i_now;
        o_item.now_prod = now_prod;
    end

endmodule

// File: hw/rtl/lbpr_fifo.sv
// Short item queue between the front and back parts.
// Depends on lbpr_pkg for the item type and depth.
module lbpr_fifo
    import lbpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_data
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage: entries need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/lbpr_back.sv
// Back part of the remarker: runs the leaky bucket on metered items and
// holds the result register. Depends on lbpr_pkg.
module lbpr_back
    import lbpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_item_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_queue,
    output logic        o_promoted
);

    logic [31:0] r_pending_bits;
    logic [31:0] r_last_tick;
    logic [31:0] r_last_prod;   // last_tick * min_rate, modulo 2^32
    logic        r_out_valid;
    logic [2:0]  r_queue;
    logic        r_promoted;

    logic [31:0] n_pending_bits;
    logic [31:0] last_prod;
    logic [31:0] drain;
    logic [32:0] drain_diff;
    logic [31:0] drained;
    logic [31:0] total;
    logic        fits;
    logic        take;

    assign take       = i_item_valid && (!r_out_valid || i_ready);
    assign o_item_pop = take;
    assign o_valid    = r_out_valid;
    assign o_queue    = r_queue;
    assign o_promoted = r_promoted;

    // Elapsed ticks times rate equals now*rate minus last*rate, modulo 2^32.
    assign last_prod = r_last_tick * i_cfg.min_rate;

    // Drain, floored at zero, then try to fit the packet.
    always_comb begin
        drain      = i_item.now_prod - r_last_prod;
        drain_diff = {1'b0, r_pending_bits} - {1'b0, drain};
        drained    = drain_diff[32] ? 32'd0 : drain_diff[31:0];
        total      = drained + i_item.add_bits;
        fits       = (total <= i_cfg.bucket_size);
        n_pending_bits = fits ? total : drained;
    end

    // Bucket state. The stored product follows a rate change when no
    // metered item updates it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_bits <= '0;
            r_last_tick    <= '0;
            r_last_prod    <= '0;
        end else if (take && i_item.metered) begin
            r_pending_bits <= n_pending_bits;
            r_last_tick    <= i_item.now;
            r_last_prod    <= i_item.now_prod;
        end else begin
            r_last_prod    <= last_prod;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_queue    <= (i_item.metered && fits) ? PROMOTED_QUEUE : i_item.queue;
            r_promoted <= i_item.metered && fits;
        end
    end

endmodule

// File: hw/rtl/leaky_bucket_priority_remarker.sv
// Top level of the leaky bucket priority remarker: configuration registers,
// front classifier, item queue and back meter. Depends on lbpr_pkg.
//
// Each packet's priority picks a queue from an eight-entry table; packets in
// queue 1 with metering enabled pass through a single leaky bucket and are
// promoted to queue 4 when they fit. One item is accepted per cycle while the
// item queue is not full. The front classifier and its now*rate multiplier
// are combinational and write the classified item into the queue at
// acceptance; the back meter takes it from the queue when the output register
// is empty or being emptied, and its bucket read-modify-write completes in the
// cycle that it takes the item, so consecutive items flow without a gap while
// the output is not stalled. A two-entry queue between the parts and the
// output register let input and output stall independently. Configuration
// writes take effect at once and are expected while no item is in flight.
module leaky_bucket_priority_remarker
    import lbpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_priority_req,
    input  logic [15:0]          i_length,
    input  logic [31:0]          i_now,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_queue,
    output logic                 o_promoted
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item head_item;
    logic  fifo_full;
    logic  fifo_empty;
    logic  item_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.meter_enable <= METER_ENABLE_RESET;
            r_cfg.queue_map    <= QUEUE_MAP_RESET;
            r_cfg.min_rate     <= MIN_RATE_RESET;
            r_cfg.bucket_size  <= BUCKET_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_METER_ENABLE: r_cfg.meter_enable <= i_cfg_data[3:0];
                REG_QUEUE_MAP:    r_cfg.queue_map    <= i_cfg_data[23:0];
                REG_MIN_RATE:     r_cfg.min_rate     <= i_cfg_data;
                REG_BUCKET_SIZE:  r_cfg.bucket_size  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_ready = !fifo_full;

    lbpr_front u_front (
        .i_cfg          (r_cfg),
        .i_priority_req (i_priority_req),
        .i_length       (i_length),
        .i_now          (i_now),
        .o_item         (front_item)
    );

    lbpr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_item),
        .o_full  (fifo_full),
        .i_pop   (item_pop),
        .o_empty (fifo_empty),
        .o_data  (head_item)
    );

    lbpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (!fifo_empty),
        .i_item       (head_item),
        .o_item_pop   (item_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_queue      (o_queue),
        .o_promoted   (o_promoted)
    );

endmodule
